### rtl/mcv_pkg.sv
package mcv_pkg;

   localparam int MAX_ROWS    = 32;
   localparam int MAX_COLS    = 32;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W      = 10;
   localparam int DEPTH_W     = 11;
   localparam int DIM_W       = 6;
   localparam int RAND_W      = 31;
   localparam int DIVISOR_W   = 32;
   localparam int STEP_W      = 5;

   localparam logic [3:0] WALL_N   = 4'b1000;
   localparam logic [3:0] WALL_S   = 4'b0100;
   localparam logic [3:0] WALL_W   = 4'b0010;
   localparam logic [3:0] WALL_E   = 4'b0001;
   localparam logic [3:0] WALL_ALL = 4'b1111;

   localparam logic [RAND_W-1:0] RAND_TOP = 31'h7FFF_FFFF;

   localparam logic [1:0] CMD_INIT = 2'd0;
   localparam logic [1:0] CMD_STEP = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [RAND_W-1:0] rand_word;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] cell_res;
      logic [3:0]        walls;
      logic              advanced;
      logic              done_res;
      logic              stack_underflow;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [RAND_W-1:0]    dividend;
      logic [DIVISOR_W-1:0] divisor;
      logic [STEP_W-1:0]    steps;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [RAND_W-1:0]    quotient;
      logic [DIVISOR_W-1:0] remainder;
   } div_rsp_type;

   // Index of r among n equal slices of the random range, for n from 1 to 4.
   // The thresholds are j * (RAND_TOP / n + 1).
   function automatic logic [1:0] pick_small(input logic [RAND_W-1:0] r,
                                             input logic [2:0] n);
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [1:0]  k;
      unique case (n)
         3'd2: begin
            t1 = 32'h4000_0000; t2 = 32'hFFFF_FFFF; t3 = 32'hFFFF_FFFF;
         end
         3'd3: begin
            t1 = 32'h2AAA_AAAB; t2 = 32'h5555_5556; t3 = 32'hFFFF_FFFF;
         end
         3'd4: begin
            t1 = 32'h2000_0000; t2 = 32'h4000_0000; t3 = 32'h6000_0000;
         end
         default: begin
            t1 = 32'h8000_0000; t2 = 32'hFFFF_FFFF; t3 = 32'hFFFF_FFFF;
         end
      endcase
      k = 2'd0;
      if ({1'b0, r} >= t1) k = 2'd1;
      if ({1'b0, r} >= t2) k = 2'd2;
      if ({1'b0, r} >= t3) k = 2'd3;
      return k;
   endfunction

endpackage

### rtl/mcv_ram.sv
module mcv_ram #(
   parameter int WIDTH  = 4,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [(1 << ADDR_W)];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mcv_div.sv
module mcv_div import mcv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   // Restoring division, one quotient bit per cycle, most significant first.
   // The dividend comes left aligned, so a short run handles a narrow value.
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [RAND_W-1:0]    dvd_ff, dvd_in;
   logic [RAND_W-1:0]    quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [DIVISOR_W:0]   trial;
   logic                 ge;

   always_comb begin
      trial  = {rem_ff, dvd_ff[RAND_W-1]};
      ge     = trial >= {1'b0, div_ff};
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = req.steps;
         dvd_in = req.dividend;
         quo_in = '0;
         rem_in = '0;
         div_in = req.divisor;
      end else if (run_ff) begin
         rem_in = ge ? DIVISOR_W'(trial - {1'b0, div_ff}) : DIVISOR_W'(trial);
         quo_in = {quo_ff[RAND_W-2:0], ge};
         dvd_in = {dvd_ff[RAND_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

### rtl/dfs_maze_carver_top.sv
// Maze carver by depth-first search with a backtracking stack. Commands enter on
// start while busy is low; each command gives exactly one result word, shown for
// a single cycle with rsp_valid, and the receiver must take it then. Init sweeps
// all 1024 wall entries, one per cycle through the single write port of the wall
// memory, then runs a serial division for the start cell. A step runs a serial
// division for the column of the current cell, reads the cell and its four
// neighbors through the one read port of the wall memory, and then carves (two
// wall writes and a stack push), backtracks (a stack read and a wall read) or,
// with an empty stack, returns to cell 0. A step after the maze is complete only
// reports the current cell. Rows and columns are set through the csr port; the
// user must write them only while no command is in flight, which the block itself
// does not enforce. Zero counts as one and values above 32 count as 32. Steps
// before the first init read wall entries never written and give meaningless results.
module dfs_maze_carver_top import mcv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_SWEEP, S_INIT_DIV, S_MOD, S_SCAN, S_SCAN_END, S_PICK,
      S_CARVE, S_POP, S_POP_DATA, S_FETCH, S_REPLY
   } state_type;

   state_type state_ff, state_in;

   logic [DIM_W-1:0]   rows_ff, cols_ff;
   logic [DIM_W-1:0]   rows_c, cols_c;
   logic [DEPTH_W-1:0] total;

   logic [RAND_W-1:0]    rand_ff, rand_in;
   logic [ADDR_W-1:0]    cur_ff, cur_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [DEPTH_W-1:0]   visited_ff, visited_in;
   logic [DEPTH_W-1:0]   sweep_ff, sweep_in;
   logic [DIVISOR_W-1:0] q1_ff, q1_in;
   logic [DIM_W-1:0]     colpos_ff, colpos_in;
   logic [2:0]           scan_ff, scan_in;
   logic [3:0]           nb_ff [5];
   logic [3:0]           nb_in [5];
   logic [ADDR_W-1:0]    nxt_ff, nxt_in;
   logic [3:0]           held_ff, held_in;
   logic                 use_held_ff, use_held_in;
   logic [ADDR_W-1:0]    reply_ff, reply_in;
   logic                 adv_ff, adv_in;
   logic                 uflow_ff, uflow_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic              wall_we;
   logic [ADDR_W-1:0] wall_waddr, wall_raddr;
   logic [3:0]        wall_wdata, wall_rdata;
   logic              stk_we;
   logic [ADDR_W-1:0] stk_waddr, stk_raddr, stk_rdata;

   // Neighbor analysis of the current cell, slots in the order west, east,
   // north, south.
   logic [DEPTH_W-1:0] cur_x, cols_x;
   logic [3:0]         cand_v;
   logic [ADDR_W-1:0]  cand_a [4];
   logic [2:0]         cand_n;
   logic [1:0]         pick_k;
   logic [2:0]         seen;
   logic [ADDR_W-1:0]  pick_a;
   logic [DEPTH_W-1:0] pick_x;
   logic [3:0]         cur_clr, nxt_clr;
   logic               accept;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (rows_ff == '0) rows_c = DIM_W'(1);
      else if (rows_ff > DIM_W'(MAX_ROWS)) rows_c = DIM_W'(MAX_ROWS);
      else rows_c = rows_ff;
      if (cols_ff == '0) cols_c = DIM_W'(1);
      else if (cols_ff > DIM_W'(MAX_COLS)) cols_c = DIM_W'(MAX_COLS);
      else cols_c = cols_ff;
      total = DEPTH_W'(rows_c) * DEPTH_W'(cols_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_W'(20);
         cols_ff <= DIM_W'(20);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROWS: rows_ff <= csr_wdata;
            CSR_COLS: cols_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      cur_x  = DEPTH_W'(cur_ff);
      cols_x = DEPTH_W'(cols_c);
      cand_a[0] = cur_ff - 1'b1;
      cand_a[1] = cur_ff + 1'b1;
      cand_a[2] = ADDR_W'(cur_x - cols_x);
      cand_a[3] = ADDR_W'(cur_x + cols_x);
      cand_v[0] = (colpos_ff != '0) && (cur_ff != '0) && (nb_ff[1] == WALL_ALL);
      cand_v[1] = (colpos_ff != cols_c - 1'b1) && (cur_x + 1'b1 < total)
                  && (nb_ff[2] == WALL_ALL);
      cand_v[2] = (cur_x >= cols_x) && (nb_ff[3] == WALL_ALL);
      cand_v[3] = (cur_x + cols_x < total) && (nb_ff[4] == WALL_ALL);
      cand_n = 3'(cand_v[0]) + 3'(cand_v[1]) + 3'(cand_v[2]) + 3'(cand_v[3]);
      pick_k = pick_small(rand_ff, cand_n);
      seen   = '0;
      pick_a = cand_a[0];
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i]) begin
            if (seen == 3'(pick_k)) pick_a = cand_a[i];
            seen = seen + 1'b1;
         end
      end
      pick_x = DEPTH_W'(pick_a);
      // Which walls go follows the cell numbers, so a one-column maze
      // opens east and west walls between vertical neighbors.
      if (pick_x == cur_x + 1'b1) begin
         cur_clr = WALL_E; nxt_clr = WALL_W;
      end else if (pick_x + 1'b1 == cur_x) begin
         cur_clr = WALL_W; nxt_clr = WALL_E;
      end else if (pick_x > cur_x) begin
         cur_clr = WALL_S; nxt_clr = WALL_N;
      end else begin
         cur_clr = WALL_N; nxt_clr = WALL_S;
      end
   end

   always_comb begin
      wall_we    = 1'b0;
      wall_waddr = sweep_ff[ADDR_W-1:0];
      wall_wdata = WALL_ALL;
      wall_raddr = reply_ff;
      stk_we     = 1'b0;
      stk_waddr  = depth_ff[ADDR_W-1:0];
      stk_raddr  = depth_ff[ADDR_W-1:0];
      div_req.start    = 1'b0;
      div_req.dividend = RAND_TOP;
      div_req.divisor  = DIVISOR_W'(total);
      div_req.steps    = STEP_W'(RAND_W);
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.cmd == CMD_INIT) begin
               div_req.start = 1'b1;
            end else if (accept && req_data.cmd == CMD_STEP && visited_ff < total) begin
               div_req.start    = 1'b1;
               div_req.dividend = {cur_ff, {(RAND_W-ADDR_W){1'b0}}};
               div_req.divisor  = DIVISOR_W'(cols_c);
               div_req.steps    = STEP_W'(ADDR_W);
            end
         end
         S_SWEEP: begin
            wall_we = 1'b1;
            if (sweep_ff == DEPTH_W'(STORE_DEPTH - 1)) begin
               div_req.start    = 1'b1;
               div_req.dividend = rand_ff;
               div_req.divisor  = q1_ff;
            end
         end
         S_SCAN: begin
            wall_raddr = (scan_ff == 3'd0) ? cur_ff : cand_a[2'(scan_ff - 1'b1)];
         end
         S_PICK: begin
            wall_we    = cand_n != '0;
            wall_waddr = cur_ff;
            wall_wdata = nb_ff[0] & ~cur_clr;
         end
         S_CARVE: begin
            wall_we    = 1'b1;
            wall_waddr = nxt_ff;
            wall_wdata = held_ff;
            stk_we     = depth_ff < DEPTH_W'(STORE_DEPTH);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rand_in      = rand_ff;
      cur_in       = cur_ff;
      depth_in     = depth_ff;
      visited_in   = visited_ff;
      sweep_in     = sweep_ff;
      q1_in        = q1_ff;
      colpos_in    = colpos_ff;
      scan_in      = scan_ff;
      nb_in        = nb_ff;
      nxt_in       = nxt_ff;
      held_in      = held_ff;
      use_held_in  = use_held_ff;
      reply_in     = reply_ff;
      adv_in       = adv_ff;
      uflow_in     = uflow_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rand_in     = req_data.rand_word;
               adv_in      = 1'b0;
               uflow_in    = 1'b0;
               use_held_in = 1'b0;
               reply_in    = cur_ff;
               sweep_in    = '0;
               priority if (req_data.cmd == CMD_INIT) begin
                  state_in = S_SWEEP;
               end else if (req_data.cmd == CMD_STEP && visited_ff < total) begin
                  state_in = S_MOD;
               end else if (req_data.cmd == CMD_READ) begin
                  reply_in = req_data.address;
                  state_in = S_FETCH;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_SWEEP: begin
            if (div_rsp.done) q1_in = DIVISOR_W'(div_rsp.quotient) + 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == DEPTH_W'(STORE_DEPTH - 1)) state_in = S_INIT_DIV;
         end
         S_INIT_DIV: begin
            if (div_rsp.done) begin
               cur_in      = div_rsp.quotient[ADDR_W-1:0];
               reply_in    = div_rsp.quotient[ADDR_W-1:0];
               depth_in    = '0;
               visited_in  = DEPTH_W'(1);
               held_in     = WALL_ALL;
               use_held_in = 1'b1;
               state_in    = S_REPLY;
            end
         end
         S_MOD: begin
            if (div_rsp.done) begin
               colpos_in = div_rsp.remainder[DIM_W-1:0];
               scan_in   = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_ff != 3'd0) nb_in[scan_ff - 1'b1] = wall_rdata;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == 3'd4) state_in = S_SCAN_END;
         end
         S_SCAN_END: begin
            nb_in[4] = wall_rdata;
            state_in = S_PICK;
         end
         S_PICK: begin
            priority if (cand_n != '0) begin
               nxt_in   = pick_a;
               held_in  = WALL_ALL & ~nxt_clr;
               state_in = S_CARVE;
            end else if (depth_ff == '0) begin
               cur_in   = '0;
               reply_in = '0;
               uflow_in = 1'b1;
               state_in = S_FETCH;
            end else begin
               depth_in = depth_ff - 1'b1;
               state_in = S_POP;
            end
         end
         S_CARVE: begin
            if (depth_ff < DEPTH_W'(STORE_DEPTH)) depth_in = depth_ff + 1'b1;
            cur_in      = nxt_ff;
            reply_in    = nxt_ff;
            visited_in  = visited_ff + 1'b1;
            adv_in      = 1'b1;
            use_held_in = 1'b1;
            state_in    = S_REPLY;
         end
         S_POP: begin
            state_in = S_POP_DATA;
         end
         S_POP_DATA: begin
            cur_in   = stk_rdata;
            reply_in = stk_rdata;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_REPLY;
         end
         S_REPLY: begin
            rsp_valid_in           = 1'b1;
            rsp_in.cell_res        = reply_ff;
            rsp_in.walls           = use_held_ff ? held_ff : wall_rdata;
            rsp_in.advanced        = adv_ff;
            rsp_in.done_res        = visited_ff >= total;
            rsp_in.stack_underflow = uflow_ff;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         depth_ff     <= '0;
         visited_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         depth_ff     <= depth_in;
         visited_ff   <= visited_in;
      end
      rand_in_use: begin
      end
      rand_ff     <= rand_in;
      sweep_ff    <= sweep_in;
      q1_ff       <= q1_in;
      colpos_ff   <= colpos_in;
      scan_ff     <= scan_in;
      nb_ff       <= nb_in;
      nxt_ff      <= nxt_in;
      held_ff     <= held_in;
      use_held_ff <= use_held_in;
      reply_ff    <= reply_in;
      adv_ff      <= adv_in;
      uflow_ff    <= uflow_in;
      rsp_ff      <= rsp_in;
   end

   mcv_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Wall bits of every cell.
   mcv_ram #(.WIDTH(4), .ADDR_W(ADDR_W)) u_wall_ram (
      .clock   (clock),
      .wr_en   (wall_we),
      .wr_addr (wall_waddr),
      .wr_data (wall_wdata),
      .rd_addr (wall_raddr),
      .rd_data (wall_rdata)
   );

   // Path of cells back to the start.
   mcv_ram #(.WIDTH(ADDR_W), .ADDR_W(ADDR_W)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (cur_ff),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

`ifndef SYNTH
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_REPLY))
      else $error("result word without a reply cycle");

   a_adv_xor_uflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.advanced && rsp_data.stack_underflow))
      else $error("carve and underflow in one word");

   a_adv_opens_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.advanced |-> rsp_data.walls != WALL_ALL)
      else $error("carved cell kept all walls");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STORE_DEPTH))
      else $error("stack depth beyond store");
`endif

endmodule

### tb/sv/testbench.sv
import mcv_pkg::*;

// Predicts the maze carver word by word and checks each result word against the
// oldest prediction. Its copy of the grid, path stack and counters follows the
// block's own state, so that every accepted command word yields one expected word.
class maze_scoreboard;
   logic [3:0]        wall_mem [STORE_DEPTH];
   logic [ADDR_W-1:0] path_mem [STORE_DEPTH];
   int unsigned       path_depth;
   int unsigned       cur_cell;
   int unsigned       visit_cnt;
   logic [DIM_W-1:0]  row_reg;
   logic [DIM_W-1:0]  col_reg;
   rsp_type           pending_q[$];
   int                fail_cnt;

   function new();
      path_depth = 0;
      cur_cell   = 0;
      visit_cnt  = 0;
      row_reg    = 6'd20;
      col_reg    = 6'd20;
      fail_cnt   = 0;
      foreach (wall_mem[i]) wall_mem[i] = 4'h0;
   endfunction

   function void set_dim(logic idx, logic [DIM_W-1:0] val);
      if (idx == CSR_ROWS) row_reg = val;
      else col_reg = val;
   endfunction

   function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      return (v > top) ? top : v;
   endfunction

   function int unsigned slice_of(int unsigned r, int unsigned n);
      return r / (32'h7FFF_FFFF / n + 1);
   endfunction

   function bit is_fresh(int unsigned c);
      return c < STORE_DEPTH && wall_mem[c] == WALL_ALL;
   endfunction

   function void carve(int unsigned c, logic [3:0] bits);
      if (c < STORE_DEPTH) wall_mem[c] = wall_mem[c] & ~bits;
   endfunction

   // Predicts the result word of one accepted command word.
   function void note_word(req_type w);
      int unsigned rows;
      int unsigned cols;
      int unsigned total;
      int unsigned hit_cell;
      int unsigned cur;
      int unsigned n;
      int unsigned k;
      int unsigned nxt;
      int unsigned cand [4];
      rsp_type     e;
      rows     = clamp_dim(row_reg, MAX_ROWS);
      cols     = clamp_dim(col_reg, MAX_COLS);
      total    = rows * cols;
      hit_cell = cur_cell;
      e        = '0;
      if (w.cmd == CMD_INIT) begin
         foreach (wall_mem[i]) wall_mem[i] = WALL_ALL;
         path_depth = 0;
         visit_cnt  = 1;
         cur_cell   = slice_of(w.rand_word, total);
         hit_cell   = cur_cell;
      end else if (w.cmd == CMD_STEP) begin
         if (visit_cnt < total) begin
            cur = cur_cell;
            n   = 0;
            if (cur % cols != 0 && cur >= 1 && is_fresh(cur - 1)) begin
               cand[n] = cur - 1; n++;
            end
            if (cur % cols != cols - 1 && cur + 1 < total && is_fresh(cur + 1)) begin
               cand[n] = cur + 1; n++;
            end
            if (cur >= cols && is_fresh(cur - cols)) begin
               cand[n] = cur - cols; n++;
            end
            if (cur + cols < total && is_fresh(cur + cols)) begin
               cand[n] = cur + cols; n++;
            end
            if (n != 0) begin
               k   = slice_of(w.rand_word, n);
               nxt = cand[(k < n) ? k : n - 1];
               if (nxt == cur + 1) begin
                  carve(cur, WALL_E); carve(nxt, WALL_W);
               end else if (nxt + 1 == cur) begin
                  carve(cur, WALL_W); carve(nxt, WALL_E);
               end else if (nxt > cur) begin
                  carve(cur, WALL_S); carve(nxt, WALL_N);
               end else begin
                  carve(cur, WALL_N); carve(nxt, WALL_S);
               end
               if (path_depth < STORE_DEPTH) begin
                  path_mem[path_depth] = ADDR_W'(cur);
                  path_depth++;
               end
               cur_cell = nxt;
               visit_cnt++;
               e.advanced = 1'b1;
            end else if (path_depth == 0) begin
               cur_cell = 0;
               e.stack_underflow = 1'b1;
            end else begin
               path_depth--;
               cur_cell = path_mem[path_depth];
            end
         end
         hit_cell = cur_cell;
      end else if (w.cmd == CMD_READ) begin
         hit_cell = w.address;
      end
      e.cell_res = ADDR_W'(hit_cell);
      e.walls    = (hit_cell < STORE_DEPTH) ? wall_mem[hit_cell] : 4'h0;
      e.done_res = (visit_cnt >= total);
      pending_q.push_back(e);
   endfunction

   function bit maze_done();
      return visit_cnt >= clamp_dim(row_reg, MAX_ROWS) * clamp_dim(col_reg, MAX_COLS);
   endfunction

   function void check_word(rsp_type a);
      rsp_type e;
      if (pending_q.size() == 0) begin
         $error("result word with no prediction waiting: %h", a);
         fail_cnt++;
         return;
      end
      e = pending_q.pop_front();
      if (a.cell_res !== e.cell_res) begin
         $error("cell_res expected %0d actual %0d", e.cell_res, a.cell_res);
         fail_cnt++;
      end
      if (a.walls !== e.walls) begin
         $error("walls expected %h actual %h", e.walls, a.walls);
         fail_cnt++;
      end
      if (a.advanced !== e.advanced) begin
         $error("advanced expected %b actual %b", e.advanced, a.advanced);
         fail_cnt++;
      end
      if (a.done_res !== e.done_res) begin
         $error("done_res expected %b actual %b", e.done_res, a.done_res);
         fail_cnt++;
      end
      if (a.stack_underflow !== e.stack_underflow) begin
         $error("stack_underflow expected %b actual %b", e.stack_underflow,
                a.stack_underflow);
         fail_cnt++;
      end
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Command 3 has no name in the package; the block echoes the current cell.
   localparam logic [1:0] CMD_ECHO = 2'd3;
   localparam int ITEM_GOAL = 1750;
   localparam int CYCLE_LIMIT = 10_000_000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic             csr_index;
   logic [DIM_W-1:0] csr_wdata;

   maze_scoreboard maze_sb;
   int             sent_cnt;
   int             idle_pct;
   int             cycle_cnt = 0;

   dfs_maze_carver_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // The receiver cannot stall the block, so every result word is taken at
   // the edge that ends its single valid cycle. Reading after the edge gives
   // the values from before it, since the block updates by nonblocking writes.
   always @(posedge clock) begin
      if (!reset && rsp_valid) maze_sb.check_word(rsp_data);
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("FAIL dfs_maze_carver_top");
         $finish;
      end
   end

   // Sends one command word. The sender may first idle for a while with start low;
   // start then stays high until the block takes the word at an edge where busy is low.
   task automatic send_word(logic [1:0] cmd, logic [RAND_W-1:0] r, logic [ADDR_W-1:0] addr);
      req_type w;
      w.cmd       = cmd;
      w.rand_word = r;
      w.address   = addr;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      maze_sb.note_word(w);
      sent_cnt++;
   endtask

   // Lets every predicted word arrive, with start low, so the block is idle.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (maze_sb.pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes one dimension register; only called after drain().
   task automatic write_dim(logic idx, logic [DIM_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      maze_sb.set_dim(idx, val);
      @(posedge clock);
   endtask

   task automatic set_grid(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
      drain();
      if ($urandom_range(1)) begin
         write_dim(CSR_ROWS, rows);
         write_dim(CSR_COLS, cols);
      end else begin
         write_dim(CSR_COLS, cols);
         write_dim(CSR_ROWS, rows);
      end
   endtask

   function automatic logic [RAND_W-1:0] pick_rand();
      case ($urandom_range(9))
         0: return '0;
         1: return RAND_TOP;
         default: return RAND_W'($urandom());
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(19))
         0: return 6'd0;
         1: return 6'd63;
         2: return 6'd1;
         3: return 6'd32;
         4: return DIM_W'($urandom_range(63, 33));
         default: return DIM_W'($urandom_range(8, 1));
      endcase
   endfunction

   initial begin
      int          budget;
      int          extra;
      int          roll;
      logic [5:0]  rdim;
      logic [5:0]  cdim;
      maze_sb   = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ROWS;
      csr_wdata = '0;
      sent_cnt  = 0;
      idle_pct  = 14;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Zero and overlarge dimensions clamp, giving one row of
      // 32 columns; the largest random word picks the last start cell.
      set_grid(6'd0, 6'd63);
      send_word(CMD_INIT, RAND_TOP, '0);
      repeat (3) send_word(CMD_STEP, RAND_TOP, '0);
      send_word(CMD_READ, '0, 10'd0);
      send_word(CMD_READ, '0, 10'd1023);
      send_word(CMD_ECHO, RAND_TOP, 10'h3FF);
      // Full grid, start at cell 0, take first and last choices.
      set_grid(6'd32, 6'd32);
      send_word(CMD_INIT, '0, '0);
      send_word(CMD_STEP, '0, '0);
      send_word(CMD_STEP, RAND_TOP, '0);
      send_word(CMD_READ, '0, 10'h155);
      send_word(CMD_READ, '0, 10'h2AA);
      // A two by two maze run to completion, then further steps once done.
      set_grid(6'd2, 6'd2);
      send_word(CMD_INIT, 31'h4000_0000, '0);
      repeat (7) send_word(CMD_STEP, 31'h2AAA_AAAB, '0);
      // A one cell grid is complete right after init.
      set_grid(6'd1, 6'd1);
      send_word(CMD_INIT, RAND_TOP, '0);
      send_word(CMD_STEP, '0, '0);
      // Enlarging a finished maze without init leaves cells to carve from
      // wherever the path now stands.
      set_grid(6'd3, 6'd1);
      repeat (4) send_word(CMD_STEP, RAND_W'($urandom()), '0);

      // Random part: one maze per phase, mostly run to completion.
      while (sent_cnt < ITEM_GOAL) begin
         if (sent_cnt > 2 * ITEM_GOAL / 3) idle_pct = 0;
         else if (sent_cnt > ITEM_GOAL / 3) idle_pct = 76;
         // Hold the sender until nothing is outstanding when just past half the goal.
         if (sent_cnt > ITEM_GOAL / 2 && sent_cnt < ITEM_GOAL / 2 + 40) drain();
         rdim = pick_dim();
         cdim = pick_dim();
         set_grid(rdim, cdim);
         // Now and then keep the old grid contents and carve on.
         if ($urandom_range(7) != 0) send_word(CMD_INIT, pick_rand(), ADDR_W'($urandom()));
         budget = 3 * maze_sb.clamp_dim(rdim, MAX_ROWS) * maze_sb.clamp_dim(cdim, MAX_COLS);
         if (budget > 250) budget = 250;
         extra = $urandom_range(3);
         while (budget > 0 && (!maze_sb.maze_done() || extra > 0)) begin
            if (maze_sb.maze_done()) extra--;
            roll = $urandom_range(99);
            if (roll < 78) send_word(CMD_STEP, pick_rand(), ADDR_W'($urandom()));
            else if (roll < 94) send_word(CMD_READ, RAND_W'($urandom()), ADDR_W'($urandom()));
            else if (roll < 97) send_word(CMD_ECHO, RAND_W'($urandom()), ADDR_W'($urandom()));
            else send_word(CMD_INIT, pick_rand(), ADDR_W'($urandom()));
            budget--;
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (maze_sb.fail_cnt == 0 && maze_sb.pending_q.size() == 0) begin
         $display("PASS dfs_maze_carver_top");
      end else begin
         $display("FAIL dfs_maze_carver_top");
      end
      $finish;
   end
endmodule
